FILE: rtl/tbcs_pkg.sv
// Shared types, codes and wrap helpers for the two-button clock-set controller.
// No dependencies; used by tbcs_edit and two_button_clock_set_controller.
package tbcs_pkg;

  localparam int unsigned HoldSecondsReset = 2;

  // Input action codes.
  localparam logic ACT_ENTER  = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    STEP_NONE   = 3'd0,
    STEP_HOUR   = 3'd1,
    STEP_MINUTE = 3'd2,
    STEP_SECOND = 3'd3,
    STEP_DONE   = 3'd4
  } step_t;

  typedef enum logic [1:0] {
    HOLD_IDLE    = 2'd0,
    HOLD_TIMING  = 2'd1,
    HOLD_LATCHED = 2'd2
  } hold_mode_t;

  typedef struct packed {
    logic       action;
    logic       button_a;
    logic       button_b;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } item_t;

  typedef struct packed {
    step_t      step;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       colon_visible;
    logic       finished;
  } result_t;

  // Step a 0..31 value up or down modulo 24. Out-of-range inputs can need
  // two corrections, so both are checked.
  function automatic logic [4:0] wrap24(input logic [4:0] v, input logic up);
    logic [5:0] t;
    begin
      t = up ? ({1'b0, v} + 6'd1) : ({1'b0, v} + 6'd23);
      if (t >= 6'd48) begin
        t = t - 6'd48;
      end else if (t >= 6'd24) begin
        t = t - 6'd24;
      end
      return t[4:0];
    end
  endfunction

  // Step a 0..63 value up or down modulo 60.
  function automatic logic [5:0] wrap60(input logic [5:0] v, input logic up);
    logic [6:0] t;
    begin
      t = up ? ({1'b0, v} + 7'd1) : ({1'b0, v} + 7'd59);
      if (t >= 7'd120) begin
        t = t - 7'd120;
      end else if (t >= 7'd60) begin
        t = t - 7'd60;
      end
      return t[5:0];
    end
  endfunction

endpackage

FILE: rtl/tbcs_edit.sv
// Edit state of the clock-set controller: step, hold tracking and the time
// being edited. Depends on tbcs_pkg. Updates its state when fire is high.
module tbcs_edit
  import tbcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  item_t      item,
  input  logic [5:0] hold_limit,
  output result_t    result
);

  step_t      step, step_next;
  hold_mode_t mode, mode_next;
  logic [5:0] start, start_next;
  logic [4:0] hours, hours_next;
  logic [5:0] minutes, minutes_next;
  logic [5:0] seconds, seconds_next;
  logic [6:0] elapsed;
  logic       both;

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= STEP_NONE;
      mode    <= HOLD_IDLE;
      start   <= '0;
      hours   <= '0;
      minutes <= '0;
      seconds <= '0;
    end else if (fire) begin
      step    <= step_next;
      mode    <= mode_next;
      start   <= start_next;
      hours   <= hours_next;
      minutes <= minutes_next;
      seconds <= seconds_next;
    end
  end

  // Seconds since the hold began, wrapping across the minute boundary.
  always_comb begin
    if (item.seconds > start) begin
      elapsed = {1'b0, item.seconds} - {1'b0, start};
    end else begin
      elapsed = {1'b0, item.seconds} + 7'd60 - {1'b0, start};
    end
  end

  assign both = item.button_a & item.button_b;

  always_comb begin
    step_next    = step;
    mode_next    = mode;
    start_next   = start;
    hours_next   = hours;
    minutes_next = minutes;
    seconds_next = seconds;

    if (item.action == ACT_ENTER) begin
      step_next    = STEP_HOUR;
      hours_next   = item.hours;
      minutes_next = item.minutes;
      seconds_next = item.seconds;
    end else begin
      if (!both) begin
        mode_next = HOLD_IDLE;
      end else begin
        unique case (mode)
          HOLD_IDLE: begin
            start_next = item.seconds;
            mode_next  = HOLD_TIMING;
          end
          HOLD_TIMING: begin
            // A hold that started in this same second never advances.
            if (item.seconds != start && elapsed >= {1'b0, hold_limit}) begin
              mode_next = HOLD_LATCHED;
              unique case (step)
                STEP_HOUR:   step_next = STEP_MINUTE;
                STEP_MINUTE: step_next = STEP_SECOND;
                STEP_SECOND: step_next = STEP_DONE;
                default:     step_next = step;
              endcase
            end
          end
          default: mode_next = mode;
        endcase
      end

      if (item.button_a != item.button_b) begin
        unique case (step)
          STEP_HOUR:   hours_next   = wrap24(hours, item.button_a);
          STEP_MINUTE: minutes_next = wrap60(minutes, item.button_a);
          STEP_SECOND: seconds_next = wrap60(seconds, item.button_a);
          default:     hours_next   = hours;
        endcase
      end
    end
  end

  always_comb begin
    result.step          = step_next;
    result.hours         = hours_next;
    result.minutes       = minutes_next;
    result.seconds       = seconds_next;
    result.colon_visible = item.seconds[0];
    result.finished      = (step_next == STEP_DONE);
  end

`ifndef SYNTH
  a_enter_hour: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == ACT_ENTER |=> step == STEP_HOUR)
    else $error("enter did not select hour editing");

  a_release_idle: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == ACT_UPDATE && !both |=> mode == HOLD_IDLE)
    else $error("hold tracking not cleared on release");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(step) && $stable(mode) && $stable(hours)
              && $stable(minutes) && $stable(seconds))
    else $error("edit state changed without a request");

  a_latch_from_timing: assert property (@(posedge clk) disable iff (rst)
    fire && mode != HOLD_TIMING |=> mode != HOLD_LATCHED || $past(mode) == HOLD_LATCHED)
    else $error("advance latched without timing a hold");

  a_step_moves_forward: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == ACT_UPDATE && step != STEP_NONE
    |=> step >= $past(step))
    else $error("edit step went backward on an update");
`endif

endmodule

FILE: rtl/two_button_clock_set_controller.sv
// Top level of the two-button clock-set controller: input register, edit
// state (tbcs_edit), result register and the hold_seconds setting.
// Depends on tbcs_pkg and tbcs_edit.

// The block takes one request per clock unless a side stalls, and returns
// one result per request, in order. A request is held in the input register,
// the edit state is read and written in the same clock as the update stage
// fires, and the result is then held in the output register; that one update
// stage sets the rate at one request per cycle. Both sides may stall freely:
// a held result stops the update stage, and the input register still takes a new
// request whenever it is empty or draining. A write to hold_seconds is taken
// at once and should only be made while no request is in flight.
module two_button_clock_set_controller
  import tbcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic       button_a,
  input  logic       button_b,
  input  logic [4:0] now_hours,
  input  logic [5:0] now_minutes,
  input  logic [5:0] now_seconds,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] edit_step,
  output logic [4:0] edit_hours,
  output logic [5:0] edit_minutes,
  output logic [5:0] edit_seconds,
  output logic       colon_visible,
  output logic       finished,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] hold_seconds
);

  logic       hold_valid;
  item_t      held_item;
  logic       fire;
  logic [5:0] hold_limit;
  result_t    result;
  result_t    out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit <= 6'(HoldSecondsReset);
    end else if (cfg_valid && cfg_ready) begin
      hold_limit <= hold_seconds;
    end
  end

  // The update stage runs when a request is held and the result slot is free
  // or being emptied this cycle.
  assign fire     = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item.action   <= action;
      held_item.button_a <= button_a;
      held_item.button_b <= button_b;
      held_item.hours    <= now_hours;
      held_item.minutes  <= now_minutes;
      held_item.seconds  <= now_seconds;
    end
  end

  tbcs_edit u_edit (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (held_item),
    .hold_limit (hold_limit),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

  assign edit_step     = out_data.step;
  assign edit_hours    = out_data.hours;
  assign edit_minutes  = out_data.minutes;
  assign edit_seconds  = out_data.seconds;
  assign colon_visible = out_data.colon_visible;
  assign finished      = out_data.finished;

endmodule

FILE: verif/tb_two_button_clock_set_controller.sv
// Testbench for two_button_clock_set_controller: directed and random requests, with
// each result checked against a model of the edit state kept in the bench.
// Depends on tbcs_pkg and the controller RTL.
module tb_two_button_clock_set_controller;
  import tbcs_pkg::*;

  class clock_set_scoreboard;
    step_t      step;
    hold_mode_t mode;
    logic [5:0] hold_start;
    logic [4:0] hrs;
    logic [5:0] mins;
    logic [5:0] secs;
    logic [5:0] hold_len;
    result_t    expected_q[$];
    int         mismatches;
    int         checked;
    int         advances;
    int         finished_seen;

    function new();
      step = STEP_NONE;
      mode = HOLD_IDLE;
      hold_start = '0;
      hrs = '0;
      mins = '0;
      secs = '0;
      hold_len = 6'(HoldSecondsReset);
      mismatches = 0;
      checked = 0;
      advances = 0;
      finished_seen = 0;
    endfunction

    function void set_hold(logic [5:0] v);
      hold_len = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int unsigned wrap_field(int unsigned v, int unsigned modulus, bit up);
      return up ? (v + 1) % modulus : (v + modulus - 1) % modulus;
    endfunction

    function void note_request(item_t it);
      int unsigned elapsed;
      result_t     want;
      if (it.action == ACT_ENTER) begin
        step = STEP_HOUR;
        hrs = it.hours;
        mins = it.minutes;
        secs = it.seconds;
      end else begin
        if (!(it.button_a && it.button_b)) begin
          mode = HOLD_IDLE;
        end else if (mode == HOLD_IDLE) begin
          hold_start = it.seconds;
          mode = HOLD_TIMING;
        end else if (mode == HOLD_TIMING && it.seconds != hold_start) begin
          // The hold is measured as a seconds difference taken around the minute.
          if (it.seconds > hold_start) begin
            elapsed = it.seconds - hold_start;
          end else begin
            elapsed = (int'(it.seconds) + 60 - int'(hold_start)) & 127;
          end
          if (elapsed >= hold_len) begin
            case (step)
              STEP_HOUR:   step = STEP_MINUTE;
              STEP_MINUTE: step = STEP_SECOND;
              STEP_SECOND: step = STEP_DONE;
              default:     step = step;
            endcase
            mode = HOLD_LATCHED;
            advances++;
          end
        end
        if (it.button_a != it.button_b) begin
          case (step)
            STEP_HOUR:   hrs = 5'(wrap_field(hrs, 24, it.button_a));
            STEP_MINUTE: mins = 6'(wrap_field(mins, 60, it.button_a));
            STEP_SECOND: secs = 6'(wrap_field(secs, 60, it.button_a));
            default:     step = step;
          endcase
        end
      end
      want.step = step;
      want.hours = hrs;
      want.minutes = mins;
      want.seconds = secs;
      want.colon_visible = it.seconds[0];
      want.finished = (step == STEP_DONE);
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 50) begin
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      end
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request pending", got.step, 0);
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (want.finished) begin
          finished_seen++;
        end
        if (got.step != want.step) begin
          report_mismatch("edit_step", got.step, want.step);
        end
        if (got.hours != want.hours) begin
          report_mismatch("edit_hours", got.hours, want.hours);
        end
        if (got.minutes != want.minutes) begin
          report_mismatch("edit_minutes", got.minutes, want.minutes);
        end
        if (got.seconds != want.seconds) begin
          report_mismatch("edit_seconds", got.seconds, want.seconds);
        end
        if (got.colon_visible != want.colon_visible) begin
          report_mismatch("colon_visible", got.colon_visible, want.colon_visible);
        end
        if (got.finished != want.finished) begin
          report_mismatch("finished", got.finished, want.finished);
        end
      end
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       action;
  logic       button_a;
  logic       button_b;
  logic [4:0] now_hours;
  logic [5:0] now_minutes;
  logic [5:0] now_seconds;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] edit_step;
  logic [4:0] edit_hours;
  logic [5:0] edit_minutes;
  logic [5:0] edit_seconds;
  logic       colon_visible;
  logic       finished;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [5:0] hold_seconds;

  clock_set_scoreboard sb;
  result_t             seen;
  bit                  quiet;
  int unsigned         wall;
  int unsigned         hold_cur;
  int                  sent;
  int                  settings_used;

  two_button_clock_set_controller DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .button_a      (button_a),
    .button_b      (button_b),
    .now_hours     (now_hours),
    .now_minutes   (now_minutes),
    .now_seconds   (now_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .edit_step     (edit_step),
    .edit_hours    (edit_hours),
    .edit_minutes  (edit_minutes),
    .edit_seconds  (edit_seconds),
    .colon_visible (colon_visible),
    .finished      (finished),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .hold_seconds  (hold_seconds)
  );

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  // The result side stalls at random, except during the quiet phase.
  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.step = step_t'(edit_step);
      seen.hours = edit_hours;
      seen.minutes = edit_minutes;
      seen.seconds = edit_seconds;
      seen.colon_visible = colon_visible;
      seen.finished = finished;
      sb.check_result(seen);
    end
  end

  function automatic item_t make_item(logic act, logic a, logic b, logic [4:0] h,
                                      logic [5:0] m, logic [5:0] s);
    item_t it;
    it.action = act;
    it.button_a = a;
    it.button_b = b;
    it.hours = h;
    it.minutes = m;
    it.seconds = s;
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send_request(item_t it);
    if (!quiet) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    action <= it.action;
    button_a <= it.button_a;
    button_b <= it.button_b;
    now_hours <= it.hours;
    now_minutes <= it.minutes;
    now_seconds <= it.seconds;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
    sent++;
    @(negedge clk);
  endtask

  // The register is only written once every pending result has come back.
  task write_hold(int unsigned v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    hold_seconds <= 6'(v);
    do @(posedge clk); while (!cfg_ready);
    sb.set_hold(6'(v));
    hold_cur = v;
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task send_update(logic a, logic b, logic [5:0] s);
    send_request(make_item(ACT_UPDATE, a, b, 5'($urandom_range(31)),
                           6'($urandom_range(63)), s));
  endtask

  // Both buttons held over a few samples, often landing right on the hold
  // length or one second short of it, then released.
  task hold_burst();
    int unsigned start_s;
    int unsigned len;
    int unsigned k;
    bit          a;
    start_s = wall;
    send_update(1'b1, 1'b1, 6'(wall));
    len = $urandom_range(1, 5);
    for (k = 0; k < len; k++) begin
      case ($urandom_range(3))
        0: wall = (wall + $urandom_range(0, 2)) % 60;
        1: wall = (start_s + hold_cur + $urandom_range(0, 1)) % 60;
        2: wall = (start_s + hold_cur + 59) % 60;
        default: wall = wall;
      endcase
      if ($urandom_range(9) == 0) begin
        send_update(1'b1, 1'b1, 6'($urandom_range(63)));
      end else begin
        send_update(1'b1, 1'b1, 6'(wall));
      end
    end
    wall = (wall + $urandom_range(0, 1)) % 60;
    a = $urandom_range(1);
    if ($urandom_range(1)) begin
      send_update(1'b0, 1'b0, 6'(wall));
    end else begin
      send_update(a, ~a, 6'(wall));
    end
  endtask

  task send_enter();
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] s;
    h = ($urandom_range(99) < 85) ? 5'($urandom_range(23)) : 5'($urandom_range(24, 31));
    m = ($urandom_range(99) < 85) ? 6'($urandom_range(59)) : 6'($urandom_range(60, 63));
    s = ($urandom_range(99) < 85) ? 6'(wall) : 6'($urandom_range(60, 63));
    send_request(make_item(ACT_ENTER, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           h, m, s));
  endtask

  task run_session();
    int unsigned n;
    int unsigned i;
    int unsigned r;
    bit          a;
    if ($urandom_range(9) != 0) begin
      send_enter();
    end
    n = $urandom_range(10, 40);
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        hold_burst();
      end else if (r < 75) begin
        a = $urandom_range(1);
        send_update(a, ~a, 6'(wall));
        wall = (wall + $urandom_range(0, 1)) % 60;
      end else if (r < 85) begin
        send_update(1'b0, 1'b0, 6'(wall));
        wall = (wall + $urandom_range(0, 3)) % 60;
      end else if (r < 95) begin
        send_request(make_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                               1'($urandom_range(1)), 5'($urandom_range(31)),
                               6'($urandom_range(63)), 6'($urandom_range(63))));
      end else begin
        send_enter();
      end
    end
  endtask

  task run_phase(int unsigned hold_v, int n, bit no_stall);
    int first;
    write_hold(hold_v);
    quiet = no_stall;
    first = sent;
    while (sent - first < n) begin
      run_session();
    end
    quiet = 1'b0;
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    wall = 0;
    hold_cur = HoldSecondsReset;
    sent = 0;
    settings_used = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_ENTER;
    button_a = 1'b0;
    button_b = 1'b0;
    now_hours = '0;
    now_minutes = '0;
    now_seconds = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    hold_seconds = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with a zero hold length.
    write_hold(0);
    send_update(1'b1, 1'b0, 6'd0);   // no step selected yet, nothing changes
    send_update(1'b1, 1'b1, 6'd5);
    send_update(1'b1, 1'b1, 6'd6);   // advance with no step: step stays, hold latches
    send_update(1'b0, 1'b0, 6'd6);
    send_request(make_item(ACT_ENTER, 1'b1, 1'b1, 5'd23, 6'd59, 6'd59));
    send_update(1'b1, 1'b0, 6'd0);   // hours wrap up
    send_update(1'b0, 1'b1, 6'd1);   // hours wrap down
    send_update(1'b1, 1'b1, 6'd10);
    send_update(1'b1, 1'b1, 6'd10);  // same second never advances
    send_update(1'b1, 1'b1, 6'd11);
    send_update(1'b1, 1'b1, 6'd40);  // still held after an advance
    send_update(1'b1, 1'b0, 6'd41);
    send_update(1'b0, 1'b1, 6'd42);
    send_update(1'b1, 1'b1, 6'd63);  // hold started on an out-of-range second
    send_update(1'b1, 1'b1, 6'd0);
    send_update(1'b0, 1'b0, 6'd1);
    send_update(1'b1, 1'b0, 6'd2);
    send_update(1'b0, 1'b1, 6'd3);
    send_update(1'b1, 1'b1, 6'd4);
    send_update(1'b1, 1'b1, 6'd5);   // reaches done
    send_update(1'b0, 1'b0, 6'd6);
    send_update(1'b1, 1'b1, 6'd7);
    send_update(1'b1, 1'b1, 6'd9);   // advance while done
    send_request(make_item(ACT_ENTER, 1'b0, 1'b0, 5'd31, 6'd63, 6'd63));
    send_update(1'b0, 1'b1, 6'd0);   // out-of-range hours stepped down

    run_phase(59, 260, 1'b0);
    run_phase(1, 260, 1'b0);
    run_phase(2, 260, 1'b1);
    run_phase(30, 260, 1'b0);
    run_phase(0, 260, 1'b0);
    run_phase($urandom_range(3, 58), 260, 1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.pending() != 0) begin
      sb.report_mismatch("results never returned", 0, sb.pending());
    end
    $display("Run covered %0d requests under %0d hold settings; %0d results checked.",
             sent, settings_used, sb.checked);
    $display("The model saw %0d hold advances and %0d results with editing finished.",
             sb.advances, sb.finished_seen);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
